FILE: design/fsa_pkg.sv
// fsa_pkg: shared types and constants for the force scatter accumulate block
// depends on nothing; imported by force_scatter_accumulate, fsa_checker and the testbench
package fsa_pkg;

  localparam int MAX_ATOMS = 1024;
  localparam int IDX_W     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int FORCE_W   = 48;
  localparam int ATOM_W    = 10;
  localparam int NB_W      = 11;
  localparam int Q_W       = 32;
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 160;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic signed [FORCE_W-1:0] z;
    logic signed [FORCE_W-1:0] y;
    logic signed [FORCE_W-1:0] x;
  } force_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CWR,
    ST_NRD,
    ST_NWR,
    ST_RWB
  } fsa_state_t;

endpackage

FILE: design/force_scatter_accumulate.sv
// force_scatter_accumulate: per-atom 3-vector force store with scatter add and read-clear
// depends on fsa_pkg
//
// usage
//   s_* channel takes one word per item; s_tuser is the op (0 accumulate, 1 read and clear)
//   m_* channel returns one word per read item: atom index and its three forces
//   the force store is one single-ported synchronous memory of MAX_ATOMS entries,
//   each holding x, y and z, with a registered read
//   accumulate: center read-modify-write, then, when the neighbor is valid, a neighbor
//   read-modify-write on the same port
//   read: the result is loaded into the output register in the write-back state after
//   acceptance, and the next item is taken while that result waits
//   if the receiver stalls with a result pending, a following read item waits in its
//   write-back cycle until the output register frees up; accumulates keep flowing
//   reset runs a clearing pass over all MAX_ATOMS entries (1024) that zeroes the store,
//   during which s_tready stays low
//   products are rounded half up to Q32.16, every store update saturates to 48 bits
module force_scatter_accumulate
  import fsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // center_atom, neighbor_atom, net_grad, env_x, env_y, env_z, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // op
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // atom_index, force_x, force_y, force_z, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  fsa_state_t state, state_next;
  logic [IDX_W-1:0] clear_cnt;

  // memory
  force_t           mem [MAX_ATOMS];
  force_t           rdata;
  force_t           mem_wdata;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_addr;

  // input fields
  logic [ATOM_W-1:0]        in_center;
  logic signed [NB_W-1:0]   in_nb;
  logic signed [Q_W-1:0]    in_net;
  logic signed [Q_W-1:0]    in_ex;
  logic signed [Q_W-1:0]    in_ey;
  logic signed [Q_W-1:0]    in_ez;
  logic [IDX_W-1:0]         in_c_idx;
  logic [IDX_W-1:0]         in_n_idx;
  logic                     in_c_ok;
  logic                     in_n_ok;
  logic signed [2*Q_W-1:0]  prod_x;
  logic signed [2*Q_W-1:0]  prod_y;
  logic signed [2*Q_W-1:0]  prod_z;

  // held item
  logic [ATOM_W-1:0]         it_center;
  logic [IDX_W-1:0]          it_c_idx;
  logic [IDX_W-1:0]          it_n_idx;
  logic                      it_c_ok;
  logic                      it_n_ok;
  logic signed [FORCE_W-1:0] hi_x;
  logic signed [FORCE_W-1:0] hi_y;
  logic signed [FORCE_W-1:0] hi_z;
  logic                      rb_x;
  logic                      rb_y;
  logic                      rb_z;

  logic accept;
  logic load_out;

  assign in_center = s_tdata[9:0];
  assign in_nb     = s_tdata[20:10];
  assign in_net    = s_tdata[52:21];
  assign in_ex     = s_tdata[84:53];
  assign in_ey     = s_tdata[116:85];
  assign in_ez     = s_tdata[148:117];

  assign in_c_idx = IDX_W'(32'(in_center));
  assign in_n_idx = IDX_W'(32'(in_nb[NB_W-2:0]));
  assign in_c_ok  = 32'(in_center) < 32'(MAX_ATOMS);
  assign in_n_ok  = !in_nb[NB_W-1] && (32'(in_nb[NB_W-2:0]) < 32'(MAX_ATOMS));

  assign prod_x = in_net * in_ex;
  assign prod_y = in_net * in_ey;
  assign prod_z = in_net * in_ez;

  assign accept = s_tvalid && s_tready;

  // saturating update with the half-up rounding bit folded into the carry
  function automatic logic signed [FORCE_W-1:0] upd(input logic signed [FORCE_W-1:0] old,
                                                     input logic signed [FORCE_W-1:0] hi,
                                                     input logic rb,
                                                     input logic sub);
    logic [FORCE_W:0] a;
    logic [FORCE_W:0] b;
    logic [FORCE_W:0] s;
    a = {old[FORCE_W-1], old};
    b = sub ? ~{hi[FORCE_W-1], hi} : {hi[FORCE_W-1], hi};
    s = a + b + (FORCE_W+1)'(sub ? !rb : rb);
    if (s[FORCE_W] != s[FORCE_W-1]) begin
      return s[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
    end
    return s[FORCE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_cnt <= clear_cnt + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_center <= in_center;
      it_c_idx  <= in_c_idx;
      it_n_idx  <= in_n_idx;
      it_c_ok   <= in_c_ok;
      it_n_ok   <= in_n_ok;
      hi_x      <= prod_x[2*Q_W-1:16];
      hi_y      <= prod_y[2*Q_W-1:16];
      hi_z      <= prod_z[2*Q_W-1:16];
      rb_x      <= prod_x[15];
      rb_y      <= prod_y[15];
      rb_z      <= prod_z[15];
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = it_c_idx;
    mem_wdata  = '0;
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clear_cnt;
        if (clear_cnt == IDX_W'(MAX_ATOMS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        mem_addr = in_c_idx;
        if (s_tvalid) begin
          mem_re     = 1'b1;
          state_next = (s_tuser[0] == OP_READ) ? ST_RWB : ST_CWR;
        end
      end
      ST_CWR: begin
        mem_we      = it_c_ok;
        mem_wdata.x = upd(rdata.x, hi_x, rb_x, 1'b1);
        mem_wdata.y = upd(rdata.y, hi_y, rb_y, 1'b1);
        mem_wdata.z = upd(rdata.z, hi_z, rb_z, 1'b1);
        state_next  = it_n_ok ? ST_NRD : ST_IDLE;
      end
      ST_NRD: begin
        mem_re     = 1'b1;
        mem_addr   = it_n_idx;
        state_next = ST_NWR;
      end
      ST_NWR: begin
        mem_we      = 1'b1;
        mem_addr    = it_n_idx;
        mem_wdata.x = upd(rdata.x, hi_x, rb_x, 1'b0);
        mem_wdata.y = upd(rdata.y, hi_y, rb_y, 1'b0);
        mem_wdata.z = upd(rdata.z, hi_z, rb_z, 1'b0);
        state_next  = ST_IDLE;
      end
      ST_RWB: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          mem_we     = it_c_ok;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {6'b0,
                  it_c_ok ? rdata.z : {FORCE_W{1'b0}},
                  it_c_ok ? rdata.y : {FORCE_W{1'b0}},
                  it_c_ok ? rdata.x : {FORCE_W{1'b0}},
                  it_center};
    end
  end

  // read item goes straight to its write-back cycle
  a_read_path: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser[0] == OP_READ) |=> state == ST_RWB)
    else $error("read item did not reach write-back");

  // a free output register is loaded in the write-back cycle
  a_read_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RWB && !m_tvalid) |=> (m_tvalid && state == ST_IDLE))
    else $error("read result not loaded");

  // neighbor write always follows a neighbor read
  a_nb_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NWR) |-> $past(state) == ST_NRD)
    else $error("neighbor write without read");

endmodule

FILE: tb/sv/fsa_checker.sv
`timescale 1ns / 1ps
// fsa_checker: watches both streams of force_scatter_accumulate, keeps a shadow force
// store, predicts each read-and-clear word and compares it field by field
// depends on fsa_pkg
module fsa_checker
  import fsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // center_atom, neighbor_atom, net_grad, env_x, env_y, env_z, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // op
  input  logic [0:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // atom_index, force_x, force_y, force_z, zero pad
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    errors,
  output int                    pending
);

  localparam longint F_MAX = (64'sd1 <<< (FORCE_W - 1)) - 64'sd1;
  localparam longint F_MIN = -(64'sd1 <<< (FORCE_W - 1));

  typedef struct packed {
    logic [ATOM_W-1:0] atom;
    force_t            f;
  } readout_t;

  force_t   force_mem [MAX_ATOMS];
  readout_t readout_q [$];
  int       err_n = 0;

  function automatic logic signed [FORCE_W-1:0] scaled_product(
      input logic signed [Q_W-1:0] a, input logic signed [Q_W-1:0] b);
    longint p;
    p = (longint'(a) * longint'(b) + 64'sd32768) >>> 16;
    return p[FORCE_W-1:0];
  endfunction

  function automatic logic signed [FORCE_W-1:0] sat_add(
      input logic signed [FORCE_W-1:0] acc, input longint delta);
    longint s;
    s = longint'(acc) + delta;
    if (s > F_MAX) s = F_MAX;
    if (s < F_MIN) s = F_MIN;
    return s[FORCE_W-1:0];
  endfunction

  task automatic report(input string what, input logic [FORCE_W-1:0] exp_v,
                        input logic [FORCE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, what, exp_v, act_v);
      err_n++;
    end
  endtask

  always @(posedge clk) begin : watch
    logic [ATOM_W-1:0]        center;
    logic signed [NB_W-1:0]   nb;
    logic signed [Q_W-1:0]    net;
    logic signed [FORCE_W-1:0] px, py, pz;
    readout_t                 got, want;
    if (rst) begin
      for (int i = 0; i < MAX_ATOMS; i++) force_mem[i] = '0;
      readout_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.atom = m_tdata[ATOM_W-1:0];
        got.f.x  = m_tdata[ATOM_W +: FORCE_W];
        got.f.y  = m_tdata[ATOM_W + FORCE_W +: FORCE_W];
        got.f.z  = m_tdata[ATOM_W + 2*FORCE_W +: FORCE_W];
        if (readout_q.size() == 0) begin
          $display("%0t mismatch: no word expected, actual atom %0d force %h %h %h",
                   $time, got.atom, got.f.x, got.f.y, got.f.z);
          err_n++;
        end else begin
          want = readout_q.pop_front();
          report("atom_index", FORCE_W'(want.atom), FORCE_W'(got.atom));
          report("force_x", want.f.x, got.f.x);
          report("force_y", want.f.y, got.f.y);
          report("force_z", want.f.z, got.f.z);
        end
      end
      if (s_tvalid && s_tready) begin
        center = s_tdata[ATOM_W-1:0];
        nb     = s_tdata[ATOM_W +: NB_W];
        net    = s_tdata[ATOM_W + NB_W +: Q_W];
        if (s_tuser[0] == OP_READ) begin
          want.atom = center;
          want.f    = '0;
          if (int'(center) < MAX_ATOMS) begin
            want.f = force_mem[center];
            force_mem[center] = '0;
          end
          readout_q.push_back(want);
        end else begin
          px = scaled_product(net, s_tdata[ATOM_W + NB_W + Q_W +: Q_W]);
          py = scaled_product(net, s_tdata[ATOM_W + NB_W + 2*Q_W +: Q_W]);
          pz = scaled_product(net, s_tdata[ATOM_W + NB_W + 3*Q_W +: Q_W]);
          if (int'(center) < MAX_ATOMS) begin
            force_mem[center].x = sat_add(force_mem[center].x, -longint'(px));
            force_mem[center].y = sat_add(force_mem[center].y, -longint'(py));
            force_mem[center].z = sat_add(force_mem[center].z, -longint'(pz));
          end
          if (nb >= 0 && int'(nb) < MAX_ATOMS) begin
            force_mem[nb].x = sat_add(force_mem[nb].x, longint'(px));
            force_mem[nb].y = sat_add(force_mem[nb].y, longint'(py));
            force_mem[nb].z = sat_add(force_mem[nb].z, longint'(pz));
          end
        end
      end
    end
    errors  <= err_n;
    pending <= readout_q.size();
  end

endmodule

FILE: tb/sv/tb_force_scatter_accumulate.sv
`timescale 1ns / 1ps
// tb_force_scatter_accumulate: directed and random stimulus for the force scatter store,
// random stalls on both streams and a long output hold-off; verdict from fsa_checker
// depends on fsa_pkg, force_scatter_accumulate and fsa_checker
module tb_force_scatter_accumulate;
  import fsa_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int QUIET_FROM  = 1650;
  localparam int HOLD_AT     = 900;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN       = 16;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [0:0]            s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    errors;
  int                    pending;

  int items_sent = 0;
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;
  bit held       = 1'b0;

  always #1 clk = ~clk;

  force_scatter_accumulate dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  fsa_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  function automatic logic signed [Q_W-1:0] rand_q();
    case ($urandom_range(0, 6))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3, 4: return Q_W'(int'($urandom_range(0, 131071)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [NB_W-1:0] rand_neighbor(input int base, input int w);
    case ($urandom_range(0, 9))
      0: return -11'sd1;
      1: return NB_W'(-int'($urandom_range(1, 1024)));
      default: return NB_W'(base + int'($urandom_range(0, w - 1)));
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [ATOM_W-1:0] center,
                           input logic signed [NB_W-1:0] nb, input logic signed [Q_W-1:0] net,
                           input logic signed [Q_W-1:0] ex, input logic signed [Q_W-1:0] ey,
                           input logic signed [Q_W-1:0] ez);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, ez, ey, ex, net, nb, center};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic read_atom(input logic [ATOM_W-1:0] a);
    send_item(OP_READ, a, NB_W'($urandom), $urandom, $urandom, $urandom, $urandom);
  endtask

  // output side: random stalls, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("** force_scatter_accumulate: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int base, w, k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // extremes of every field, rounding around the half step
    send_item(OP_ACCUM, 10'd0, 11'sd1023, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    send_item(OP_ACCUM, 10'd1023, -11'sd1, 32'sh8000_0000, 32'sh8000_0000, 1, -1);
    send_item(OP_ACCUM, 10'd2, 11'sd3, 1, 32768, 32769, -32769);
    send_item(OP_ACCUM, 10'd2, 11'sd3, -1, 32768, 32767, -32768);
    // negative neighbors other than -1
    send_item(OP_ACCUM, 10'd4, -11'sd1024, 65536, 65536, -65536, 12345);
    send_item(OP_ACCUM, 10'd4, -11'sd5, 32'sh0001_8000, 32'sh0002_0000, -3, 32'sh7fff_ffff);
    // neighbor is the center
    send_item(OP_ACCUM, 10'd6, 11'sd6, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 77);
    // saturation both ways
    repeat (4) send_item(OP_ACCUM, 10'd8, 11'sd9, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh7fff_ffff, 32'sh8000_0000);
    send_item(OP_ACCUM, 10'd8, 11'sd8, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 1);
    send_item(OP_ACCUM, 10'd9, 11'sd9, 32'sh7fff_ffff, 32'sh7fff_ffff, -1, 32'sh8000_0000);
    read_atom(10'd0);
    read_atom(10'd1023);
    read_atom(10'd2);
    read_atom(10'd3);
    read_atom(10'd4);
    read_atom(10'd5);
    read_atom(10'd6);
    read_atom(10'd8);
    read_atom(10'd9);
    read_atom(10'd8);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
      if (items_sent >= HOLD_AT && !held) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) begin
        // noise: any op, any field value
        repeat ($urandom_range(1, 6))
          send_item(($urandom_range(0, 1) != 0) ? OP_READ : OP_ACCUM, ATOM_W'($urandom),
                    NB_W'($urandom), rand_q(), rand_q(), rand_q(), rand_q());
      end else begin
        // one frame over a small window of atoms, then read it all back
        base = $urandom_range(0, MAX_ATOMS - 8);
        w    = $urandom_range(2, 8);
        k    = $urandom_range(2, 16);
        repeat (k)
          send_item(OP_ACCUM, ATOM_W'(base + int'($urandom_range(0, w - 1))),
                    rand_neighbor(base, w), rand_q(), rand_q(), rand_q(), rand_q());
        for (int i = 0; i < w; i++) read_atom(ATOM_W'(base + i));
      end
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("** force_scatter_accumulate: PASSED **");
    else
      $display("** force_scatter_accumulate: FAILED **");
    $finish;
  end

endmodule

FILE: force_scatter_accumulate.f
design/fsa_pkg.sv
design/force_scatter_accumulate.sv
tb/sv/fsa_checker.sv
tb/sv/tb_force_scatter_accumulate.sv
